// ===== rtl/rrts_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package rrts_pkg;

   localparam int MaxTasksDefault = 8;
   localparam int StackLimitDefault = 128;

   localparam logic [1:0] ModeCreate = 2'd0;
   localparam logic [1:0] ModeTick = 2'd1;
   localparam logic [1:0] ModeYield = 2'd2;
   localparam logic [1:0] ModeDelay = 2'd3;

   localparam logic [1:0] StUnused = 2'd0;
   localparam logic [1:0] StReady = 2'd1;
   localparam logic [1:0] StRunning = 2'd2;
   localparam logic [1:0] StDelay = 2'd3;

   localparam logic [1:0] OutOk = 2'd0;
   localparam logic [1:0] OutNoSpace = 2'd1;
   localparam logic [1:0] OutEmpty = 2'd2;

   localparam logic CsrStackBaseStart = 1'b0;
   localparam logic CsrStackBytes = 1'b1;

   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] priority_req;
      logic [15:0] delay_ticks;
   } req_word_type;

   typedef struct packed {
      logic [3:0] running_task;
      logic switched;
      logic [1:0] outcome;
      logic [2:0] created_task;
      logic [6:0] stack_base;
   } rsp_word_type;

endpackage
`default_nettype wire

// ===== rtl/round_robin_task_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Steps: a create word goes straight to the response; a yield or delay first rotates the
// ready ring (a delay with nothing running does not). A tick does a task-table read and
// write-back per task for the sleep countdown, then a read-modify-write of the running
// task's slice and a rotation when it expires (with nothing running, just the rotation).
// One word is in work at a time; the next is taken once the response has been taken.
// Synchronous active-high reset: all tasks unused, queue empty, nothing running.
module round_robin_task_scheduler
   import rrts_pkg::*;
#(
   parameter int MAX_TASKS = MaxTasksDefault,
   parameter int STACK_LIMIT = StackLimitDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire req_word_type req_word,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rsp_word_type rsp_word,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic csr_index,
   input wire logic [6:0] csr_wdata
);

   localparam int IdW = $clog2(MAX_TASKS);
   localparam int CntW = $clog2(MAX_TASKS + 1);
   localparam int AddrW = $clog2(STACK_LIMIT + 128);
   localparam logic [CntW-1:0] NoTask = CntW'(MAX_TASKS);
   localparam logic [IdW-1:0] LastId = IdW'(MAX_TASKS - 1);

   // One task-table entry: priority, slice and sleep counters.
   typedef struct packed {
      logic [7:0] prio;
      logic [7:0] slice;
      logic [15:0] sleep;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE, S_SWEEP_RD, S_SWEEP_WR, S_CUR_RD, S_CUR_WR, S_ROTATE, S_DONE
   } state_type;

   // Task table memory and the ready ring memory.
   entry_type table_mem [MAX_TASKS];
   logic [IdW-1:0] ring_mem [MAX_TASKS];
   entry_type rd_data_ff;
   logic [IdW-1:0] ring_rd_ff;

   // Per-task state codes stay in flip-flops so that reset clears them at once.
   logic [1:0] tstate_ff [MAX_TASKS];

   state_type state_ff;
   req_word_type req_ff;
   logic [6:0] bytes_ff;
   logic [AddrW-1:0] next_addr_ff;
   logic [CntW-1:0] made_ff, count_ff, cur_ff, before_ff;
   logic [IdW-1:0] head_ff, tail_ff, idx_ff;
   logic [1:0] outcome_ff;
   logic rsp_valid_ff;
   rsp_word_type rsp_ff;

   // Memory control driven by the sequencer.
   logic tab_we, ring_we;
   logic [IdW-1:0] tab_addr, ring_waddr;
   entry_type tab_wdata;
   logic [IdW-1:0] ring_wdata;

   logic [AddrW-1:0] end_addr;
   logic create_fail;
   logic [IdW-1:0] cur_id;
   logic [15:0] sleep_dec;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_ff;
   assign end_addr = next_addr_ff + AddrW'(bytes_ff);
   assign create_fail = (made_ff >= NoTask) || (end_addr > AddrW'(STACK_LIMIT));
   assign cur_id = cur_ff[IdW-1:0];
   assign sleep_dec = (rd_data_ff.sleep != 16'd0) ? rd_data_ff.sleep - 16'd1 : 16'd0;

   // Memory addressing and write data per sequencer step.
   always_comb begin
      tab_we = 1'b0;
      tab_addr = idx_ff;
      tab_wdata = rd_data_ff;
      ring_we = 1'b0;
      ring_waddr = tail_ff;
      ring_wdata = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            // Fetch the running task's entry so that a delay can write it back.
            tab_addr = cur_id;
            if (req_valid && !req_stall && req_word.mode == ModeCreate && !create_fail) begin
               tab_we = 1'b1;
               tab_addr = made_ff[IdW-1:0];
               tab_wdata = '{prio: req_word.priority_req, slice: req_word.priority_req,
                             sleep: 16'd0};
               ring_we = 1'b1;
               ring_wdata = made_ff[IdW-1:0];
            end
         end
         S_SWEEP_WR: begin
            tab_we = (tstate_ff[idx_ff] == StDelay);
            tab_wdata.sleep = sleep_dec;
            ring_we = tab_we && (sleep_dec == 16'd0) && (count_ff < NoTask);
         end
         S_CUR_RD: tab_addr = cur_id;
         S_CUR_WR: begin
            tab_addr = cur_id;
            tab_we = 1'b1;
            tab_wdata.slice = (rd_data_ff.slice <= 8'd1) ? rd_data_ff.prio
                                                         : rd_data_ff.slice - 8'd1;
         end
         S_ROTATE: begin
            // Old task goes to the tail; the delay case writes its sleep count.
            tab_addr = cur_id;
            ring_wdata = cur_id;
            ring_we = (cur_ff != NoTask) && (count_ff != '0);
            if (req_ff.mode == ModeDelay && cur_ff != NoTask) begin
               ring_we = 1'b0;
               tab_we = 1'b1;
               tab_wdata.sleep = (req_ff.delay_ticks == 16'd0) ? 16'd1 : req_ff.delay_ticks;
            end
         end
         default: ;
      endcase
   end

   // Synchronous memories with registered read data. A ring write to the head slot
   // is passed straight to the head read so that a task queued on the last sweep
   // step is seen by the rotation that follows.
   always_ff @(posedge clock) begin
      if (tab_we) begin
         table_mem[tab_addr] <= tab_wdata;
      end
      rd_data_ff <= table_mem[tab_addr];
      if (ring_we) begin
         ring_mem[ring_waddr] <= ring_wdata;
      end
      ring_rd_ff <= (ring_we && ring_waddr == head_ff) ? ring_wdata : ring_mem[head_ff];
   end

   // Sequencer, control registers and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         bytes_ff <= 7'd18;
         next_addr_ff <= AddrW'(48);
         made_ff <= '0;
         count_ff <= '0;
         head_ff <= '0;
         tail_ff <= '0;
         cur_ff <= NoTask;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_TASKS; i++) begin
            tstate_ff[i] <= StUnused;
         end
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            unique case (csr_index)
               CsrStackBaseStart: begin
                  if (made_ff == '0) begin
                     next_addr_ff <= AddrW'(csr_wdata);
                  end
               end
               CsrStackBytes: bytes_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (ring_we) begin
            tail_ff <= (tail_ff == LastId) ? '0 : tail_ff + 1'b1;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && !req_stall) begin
                  req_ff <= req_word;
                  before_ff <= cur_ff;
                  outcome_ff <= OutOk;
                  idx_ff <= '0;
                  unique case (req_word.mode)
                     ModeCreate: begin
                        rsp_ff.created_task <= '0;
                        rsp_ff.stack_base <= '0;
                        if (create_fail) begin
                           outcome_ff <= OutNoSpace;
                        end else begin
                           rsp_ff.created_task <= 3'(made_ff);
                           rsp_ff.stack_base <= 7'(next_addr_ff);
                           next_addr_ff <= end_addr;
                           tstate_ff[made_ff[IdW-1:0]] <= StReady;
                           made_ff <= made_ff + 1'b1;
                           count_ff <= count_ff + 1'b1;
                        end
                        state_ff <= S_DONE;
                     end
                     ModeTick: begin
                        rsp_ff.created_task <= '0;
                        rsp_ff.stack_base <= '0;
                        state_ff <= S_SWEEP_RD;
                     end
                     ModeYield: begin
                        rsp_ff.created_task <= '0;
                        rsp_ff.stack_base <= '0;
                        state_ff <= S_ROTATE;
                     end
                     ModeDelay: begin
                        rsp_ff.created_task <= '0;
                        rsp_ff.stack_base <= '0;
                        if (cur_ff == NoTask) begin
                           outcome_ff <= OutEmpty;
                           state_ff <= S_DONE;
                        end else begin
                           state_ff <= S_ROTATE;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_SWEEP_RD: state_ff <= S_SWEEP_WR;
            S_SWEEP_WR: begin
               if (tab_we && sleep_dec == 16'd0) begin
                  tstate_ff[idx_ff] <= StReady;
                  if (count_ff < NoTask) begin
                     count_ff <= count_ff + 1'b1;
                  end
               end
               if (idx_ff == LastId) begin
                  if (cur_ff == NoTask) begin
                     state_ff <= S_ROTATE;
                  end else begin
                     state_ff <= S_CUR_RD;
                  end
               end else begin
                  idx_ff <= idx_ff + 1'b1;
                  state_ff <= S_SWEEP_RD;
               end
            end
            S_CUR_RD: state_ff <= S_CUR_WR;
            S_CUR_WR: begin
               state_ff <= (rd_data_ff.slice <= 8'd1) ? S_ROTATE : S_DONE;
            end
            S_ROTATE: begin
               // Ring head data was read from the head pointer last cycle.
               if (req_ff.mode == ModeDelay) begin
                  tstate_ff[cur_id] <= StDelay;
               end
               if (count_ff == '0) begin
                  if (req_ff.mode == ModeDelay) begin
                     cur_ff <= NoTask;
                  end else begin
                     outcome_ff <= OutEmpty;
                  end
               end else begin
                  if (cur_ff != NoTask && req_ff.mode != ModeDelay) begin
                     tstate_ff[cur_id] <= StReady;
                  end else begin
                     count_ff <= count_ff - 1'b1;
                  end
                  head_ff <= (head_ff == LastId) ? '0 : head_ff + 1'b1;
                  cur_ff <= CntW'(ring_rd_ff);
                  tstate_ff[ring_rd_ff] <= StRunning;
               end
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_ff.running_task <= 4'(cur_ff);
               rsp_ff.switched <= (cur_ff != before_ff);
               rsp_ff.outcome <= outcome_ff;
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire
